// ----- hdl/lcdws_pkg.sv -----
// shared types, constants and helper functions for the character lcd write sequencer
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package lcdws_pkg;

	localparam int TIMER_BITS = 16;
	localparam logic [32:0] TIMER_MAX = (33'd1 << TIMER_BITS) - 33'd1;

	localparam int CFG_W = 16;
	localparam int ADDR_W = 5;
	localparam int DATA_W = 32;

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W = $clog2(QUEUE_DEPTH);

	localparam logic [3:0] INIT_NIBBLES = 4'd4;
	localparam logic [3:0] INIT_TOTAL = 4'd9;
	localparam logic [3:0] NIB_ONES = 4'hF;
	localparam logic [7:0] BUS_RELEASED = 8'hFF;
	localparam logic [7:0] INIT_NIB_A = 8'h30;
	localparam logic [7:0] INIT_NIB_B = 8'h20;
	localparam logic [7:0] CMD_FUNCTION_SET = 8'h28;
	localparam logic [7:0] CMD_DISPLAY_OFF = 8'h08;
	localparam logic [7:0] CMD_CLEAR = 8'h01;
	localparam logic [7:0] CMD_HOME = 8'h02;
	localparam logic [7:0] CMD_ENTRY_MODE = 8'h06;
	localparam logic [7:0] CMD_DISPLAY_ON = 8'h0C;

	localparam logic [1:0] OP_TICK = 2'd0;
	localparam logic [1:0] OP_WRITE = 2'd1;
	localparam logic [1:0] OP_INIT = 2'd2;

	localparam logic [2:0] REG_POWER_UP = 3'd0;
	localparam logic [2:0] REG_SETUP = 3'd1;
	localparam logic [2:0] REG_ENABLE = 3'd2;
	localparam logic [2:0] REG_HOLD = 3'd3;
	localparam logic [2:0] REG_POST_WRITE = 3'd4;
	localparam logic [2:0] REG_LONG_EXTRA = 3'd5;

	typedef struct packed {
		logic [1:0] op;
		logic [7:0] byte_value;
		logic       is_data;
	} item_t;

	typedef struct packed {
		logic [7:0] bus_out;
		logic       select_out;
		logic       rw_out;
		logic       enable_out;
		logic       busy_res;
		logic       rejected;
		logic       done_res;
	} result_t;

	typedef enum logic [1:0] {
		K_TICK,
		K_WRITE,
		K_INIT,
		K_NOP
	} kind_t;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] byte_value;
		logic       is_data;
	} req_t;

	typedef struct packed {
		logic [CFG_W-1:0] power_up_ticks;
		logic [CFG_W-1:0] setup_ticks;
		logic [CFG_W-1:0] enable_ticks;
		logic [CFG_W-1:0] hold_ticks;
		logic [CFG_W-1:0] post_write_ticks;
		logic [CFG_W-1:0] long_cmd_extra_ticks;
	} cfg_t;

	typedef enum logic [5:0] {
		PH_IDLE   = 6'b000001,
		PH_POWER  = 6'b000010,
		PH_SETUP  = 6'b000100,
		PH_ENABLE = 6'b001000,
		PH_HOLD   = 6'b010000,
		PH_GAP    = 6'b100000
	} phase_t;

	typedef struct packed {
		phase_t                phase;
		logic [TIMER_BITS-1:0] wait_count;
		logic [7:0]            byte_latch;
		logic                  select_latch;
		logic                  low_nibble_next;
		logic [3:0]            init_step;
		logic                  in_init;
		logic                  long_cmd_pending;
	} seq_state_t;

	typedef struct packed {
		logic valid;
		req_t req;
	} queue_head_t;

	function automatic logic [TIMER_BITS-1:0] sat_dur(input logic [CFG_W:0] d);
		logic [32:0] dw;
		dw = 33'(d);
		if (dw > TIMER_MAX) begin
			sat_dur = TIMER_MAX[TIMER_BITS-1:0];
		end else begin
			sat_dur = TIMER_BITS'(d);
		end
	endfunction

	function automatic logic [7:0] init_cmd(input logic [3:0] k);
		unique case (k)
			4'd0: init_cmd = CMD_FUNCTION_SET;
			4'd1: init_cmd = CMD_DISPLAY_OFF;
			4'd2: init_cmd = CMD_CLEAR;
			4'd3: init_cmd = CMD_ENTRY_MODE;
			default: init_cmd = CMD_DISPLAY_ON;
		endcase
	endfunction

endpackage

`default_nettype wire

// ----- hdl/char_lcd_4bit_write_sequencer_top.sv -----
// top level of the 4-bit character lcd write sequencer
// depends on lcdws_pkg, lcdws_cfg, lcdws_front and lcdws_seq
`timescale 1ns / 1ps
`default_nettype none

// Every accepted request (tick, byte write, init start, or the unused code)
// yields exactly one result carrying the pin levels and the busy, rejected
// and done flags after that request. A request goes into a two-entry queue
// and the sequencer takes one per cycle while its result slot is free and
// it is not settling, so requests stream at one per clock. When a request
// leaves it on a zero-length phase, it steps through one further phase per
// cycle while the slot is free, until idle or a phase with time left (the
// enable phase always lasts at least one tick); the queue still accepts.
// Results sit in an output register, so a stalled consumer does not stop
// intake until the queue fills. Timing registers are written over the
// configuration port at byte address 4 * index.

module char_lcd_4bit_write_sequencer_top import lcdws_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              req_valid,
	output logic                   req_stall,
	input  wire item_t             req,
	output logic                   res_valid,
	input  wire logic              res_stall,
	output result_t                res,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [ADDR_W-1:0] paddr,
	input  wire logic [DATA_W-1:0] pwdata,
	output logic      [DATA_W-1:0] prdata,
	output logic                   pready
);

	cfg_t        cfg;
	queue_head_t head;
	logic        pop;

	lcdws_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	lcdws_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.pop       (pop),
		.head      (head)
	);

	lcdws_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.head      (head),
		.pop       (pop),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res)
	);

endmodule

`default_nettype wire

// ----- hdl/lcdws_cfg.sv -----
// timing register bank behind the apb-style configuration port
// depends on lcdws_pkg
`timescale 1ns / 1ps
`default_nettype none

module lcdws_cfg import lcdws_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [ADDR_W-1:0] paddr,
	input  wire logic [DATA_W-1:0] pwdata,
	output logic      [DATA_W-1:0] prdata,
	output logic                   pready,
	output cfg_t                   cfg
);

	cfg_t cfg_q;
	logic wr_en;
	logic [2:0] idx;

	assign wr_en = psel && penable && pwrite;
	assign idx = paddr[ADDR_W-1:2];
	assign pready = 1'b1;
	assign cfg = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.power_up_ticks <= CFG_W'(100);
			cfg_q.setup_ticks <= CFG_W'(1);
			cfg_q.enable_ticks <= CFG_W'(5);
			cfg_q.hold_ticks <= CFG_W'(1);
			cfg_q.post_write_ticks <= CFG_W'(2);
			cfg_q.long_cmd_extra_ticks <= CFG_W'(5);
		end else if (wr_en) begin
			unique case (idx)
				REG_POWER_UP: cfg_q.power_up_ticks <= pwdata[CFG_W-1:0];
				REG_SETUP: cfg_q.setup_ticks <= pwdata[CFG_W-1:0];
				REG_ENABLE: cfg_q.enable_ticks <= pwdata[CFG_W-1:0];
				REG_HOLD: cfg_q.hold_ticks <= pwdata[CFG_W-1:0];
				REG_POST_WRITE: cfg_q.post_write_ticks <= pwdata[CFG_W-1:0];
				REG_LONG_EXTRA: cfg_q.long_cmd_extra_ticks <= pwdata[CFG_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_POWER_UP: prdata = DATA_W'(cfg_q.power_up_ticks);
			REG_SETUP: prdata = DATA_W'(cfg_q.setup_ticks);
			REG_ENABLE: prdata = DATA_W'(cfg_q.enable_ticks);
			REG_HOLD: prdata = DATA_W'(cfg_q.hold_ticks);
			REG_POST_WRITE: prdata = DATA_W'(cfg_q.post_write_ticks);
			REG_LONG_EXTRA: prdata = DATA_W'(cfg_q.long_cmd_extra_ticks);
			default: prdata = '0;
		endcase
	end

endmodule

`default_nettype wire

// ----- hdl/lcdws_front.sv -----
// intake stage: classifies each request and holds it in a short queue for the sequencer
// depends on lcdws_pkg
`timescale 1ns / 1ps
`default_nettype none

module lcdws_front import lcdws_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  req_valid,
	output logic       req_stall,
	input  wire item_t req,
	input  wire logic  pop,
	output queue_head_t head
);

	req_t              q_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   count_q;
	logic              push;
	req_t              cls;

	assign req_stall = (count_q == (QPTR_W+1)'(QUEUE_DEPTH));
	assign push = req_valid && !req_stall;

	always_comb begin
		cls.byte_value = req.byte_value;
		cls.is_data = req.is_data;
		unique case (req.op)
			OP_TICK: cls.kind = K_TICK;
			OP_WRITE: cls.kind = K_WRITE;
			OP_INIT: cls.kind = K_INIT;
			default: cls.kind = K_NOP;
		endcase
	end

	always_ff @(posedge clk) begin
		if (push) begin
			q_q[wr_ptr_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + (QPTR_W+1)'(1);
			end else if (pop && !push) begin
				count_q <= count_q - (QPTR_W+1)'(1);
			end
		end
	end

	assign head.valid = (count_q != '0);
	assign head.req = q_q[rd_ptr_q];

endmodule

`default_nettype wire

// ----- hdl/lcdws_seq.sv -----
// bus sequencer: phase state machine, tick countdown and result register
// depends on lcdws_pkg
`timescale 1ns / 1ps
`default_nettype none

module lcdws_seq import lcdws_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire cfg_t        cfg,
	input  wire queue_head_t head,
	output logic             pop,
	output logic             res_valid,
	input  wire logic        res_stall,
	output result_t          res
);

	typedef enum logic [1:0] {
		SQ_TAKE   = 2'b01,
		SQ_SETTLE = 2'b10
	} sq_t;

	sq_t        sq_q;
	seq_state_t st_q;
	logic       rej_q;
	logic       done_q;
	logic       res_valid_q;
	result_t    res_q;

	seq_state_t take_st;
	logic       take_rej;
	seq_state_t adv_st;
	logic       adv_done;
	logic       slot_free;
	logic       emit;
	result_t    emit_res;

	function automatic logic needs_step(input seq_state_t s);
		needs_step = (s.phase != PH_IDLE) && (s.wait_count == '0);
	endfunction

	function automatic seq_state_t start_item(input seq_state_t s, input cfg_t c);
		seq_state_t r;
		r = s;
		r.low_nibble_next = 1'b0;
		r.select_latch = 1'b0;
		if (s.init_step < INIT_NIBBLES) begin
			r.byte_latch = (s.init_step < 4'd3) ? INIT_NIB_A : INIT_NIB_B;
			r.long_cmd_pending = 1'b0;
		end else begin
			r.byte_latch = init_cmd(s.init_step - INIT_NIBBLES);
			r.long_cmd_pending = (r.byte_latch == CMD_CLEAR) || (r.byte_latch == CMD_HOME);
		end
		r.phase = PH_SETUP;
		r.wait_count = sat_dur({1'b0, c.setup_ticks});
		start_item = r;
	endfunction

	function automatic seq_state_t finish_item(input seq_state_t s);
		seq_state_t r;
		r = s;
		r.phase = PH_IDLE;
		r.wait_count = '0;
		r.in_init = 1'b0;
		r.init_step = '0;
		r.low_nibble_next = 1'b0;
		r.long_cmd_pending = 1'b0;
		finish_item = r;
	endfunction

	function automatic result_t make_res(input seq_state_t s, input logic rej, input logic dn);
		result_t    r;
		logic [3:0] nib;
		if (s.phase == PH_GAP) begin
			nib = (s.in_init && s.init_step < INIT_NIBBLES) ? s.byte_latch[7:4]
			                                                : s.byte_latch[3:0];
		end else begin
			nib = s.low_nibble_next ? s.byte_latch[3:0] : s.byte_latch[7:4];
		end
		if (s.phase == PH_IDLE || s.phase == PH_POWER) begin
			r.bus_out = BUS_RELEASED;
		end else begin
			r.bus_out = {nib, NIB_ONES};
		end
		r.select_out = s.in_init ? 1'b0 : s.select_latch;
		r.rw_out = 1'b0;
		r.enable_out = (s.phase == PH_ENABLE);
		r.busy_res = (s.phase != PH_IDLE);
		r.rejected = rej;
		r.done_res = dn;
		make_res = r;
	endfunction

	// apply one accepted request to the current state
	always_comb begin
		take_st = st_q;
		take_rej = 1'b0;
		unique case (head.req.kind)
			K_TICK: begin
				if (st_q.phase != PH_IDLE && st_q.wait_count != '0) begin
					take_st.wait_count = st_q.wait_count - TIMER_BITS'(1);
				end
			end
			K_WRITE: begin
				if (st_q.phase != PH_IDLE) begin
					take_rej = 1'b1;
				end else begin
					take_st.byte_latch = head.req.byte_value;
					take_st.select_latch = head.req.is_data;
					take_st.long_cmd_pending = !head.req.is_data &&
						(head.req.byte_value == CMD_CLEAR || head.req.byte_value == CMD_HOME);
					take_st.low_nibble_next = 1'b0;
					take_st.in_init = 1'b0;
					take_st.phase = PH_SETUP;
					take_st.wait_count = sat_dur({1'b0, cfg.setup_ticks});
				end
			end
			K_INIT: begin
				if (st_q.phase != PH_IDLE) begin
					take_rej = 1'b1;
				end else begin
					take_st.in_init = 1'b1;
					take_st.init_step = '0;
					take_st.select_latch = 1'b0;
					take_st.low_nibble_next = 1'b0;
					take_st.long_cmd_pending = 1'b0;
					take_st.phase = PH_POWER;
					take_st.wait_count = sat_dur({1'b0, cfg.power_up_ticks});
				end
			end
			default: ;
		endcase
	end

	// leave one expired phase
	always_comb begin
		adv_st = st_q;
		adv_done = 1'b0;
		unique case (st_q.phase)
			PH_POWER: adv_st = start_item(st_q, cfg);
			PH_SETUP: begin
				adv_st.phase = PH_ENABLE;
				adv_st.wait_count = (cfg.enable_ticks == '0) ? TIMER_BITS'(1)
				                                             : sat_dur({1'b0, cfg.enable_ticks});
			end
			PH_ENABLE: begin
				adv_st.phase = PH_HOLD;
				adv_st.wait_count = sat_dur({1'b0, cfg.hold_ticks});
			end
			PH_HOLD: begin
				if (st_q.in_init && st_q.init_step < INIT_NIBBLES) begin
					adv_st.phase = PH_GAP;
					if (st_q.init_step < 4'd2) begin
						adv_st.wait_count = sat_dur({1'b0, cfg.long_cmd_extra_ticks});
					end else if (st_q.init_step == 4'd2) begin
						adv_st.wait_count = sat_dur({1'b0, cfg.post_write_ticks});
					end else begin
						adv_st.wait_count = '0;
					end
				end else if (!st_q.low_nibble_next) begin
					adv_st.low_nibble_next = 1'b1;
					adv_st.phase = PH_SETUP;
					adv_st.wait_count = sat_dur({1'b0, cfg.setup_ticks});
				end else begin
					adv_st.low_nibble_next = 1'b0;
					adv_st.phase = PH_GAP;
					adv_st.wait_count = sat_dur({1'b0, cfg.post_write_ticks} +
						(st_q.long_cmd_pending ? {1'b0, cfg.long_cmd_extra_ticks} : '0));
				end
			end
			PH_GAP: begin
				if (st_q.in_init && (st_q.init_step + 4'd1) < INIT_TOTAL) begin
					adv_st.init_step = st_q.init_step + 4'd1;
					adv_st = start_item(adv_st, cfg);
				end else begin
					adv_st = finish_item(st_q);
					adv_done = 1'b1;
				end
			end
			default: begin
				adv_st = finish_item(st_q);
				adv_done = 1'b1;
			end
		endcase
	end

	assign slot_free = !res_valid_q || !res_stall;
	assign pop = (sq_q == SQ_TAKE) && slot_free && head.valid;

	always_comb begin
		emit = 1'b0;
		emit_res = make_res(take_st, take_rej, 1'b0);
		unique case (sq_q)
			SQ_TAKE: begin
				emit = pop && !needs_step(take_st);
			end
			SQ_SETTLE: begin
				emit = slot_free && !needs_step(adv_st);
				emit_res = make_res(adv_st, rej_q, done_q || adv_done);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sq_q <= SQ_TAKE;
			st_q <= '{phase: PH_IDLE, default: '0};
			rej_q <= 1'b0;
			done_q <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			unique case (sq_q)
				SQ_TAKE: begin
					if (pop) begin
						st_q <= take_st;
						rej_q <= take_rej;
						done_q <= 1'b0;
						if (needs_step(take_st)) begin
							sq_q <= SQ_SETTLE;
						end
					end
				end
				SQ_SETTLE: begin
					if (slot_free) begin
						st_q <= adv_st;
						done_q <= done_q || adv_done;
						if (!needs_step(adv_st)) begin
							sq_q <= SQ_TAKE;
						end
					end
				end
				default: sq_q <= SQ_TAKE;
			endcase
			if (emit) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			res_q <= emit_res;
		end
	end

	assign res_valid = res_valid_q;
	assign res = res_q;

endmodule

`default_nettype wire

// ----- test/tb_char_lcd_4bit_write_sequencer_top.sv -----
// self-checking testbench for the 4-bit character lcd write sequencer
// predicts pin levels and flags per request and compares every result in order
// depends on lcdws_pkg and char_lcd_4bit_write_sequencer_top
`timescale 1ns / 1ps
`default_nettype none

module tb_char_lcd_4bit_write_sequencer_top;
	import lcdws_pkg::*;

	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam int MAX_REPORTS = 10;
	localparam int SETTLE_CYCLES = 32;
	localparam int QUIET_LIMIT = 1000;
	localparam int RANDOM_REQUESTS = 45;
	localparam int SAT_TICKS = 8;

	localparam item_t TICK_ITEM = '{OP_TICK, 8'h00, 1'b0};
	localparam result_t PINS_IDLE = '{BUS_RELEASED, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0};
	localparam result_t PINS_BUSY = '{BUS_RELEASED, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0};
	localparam result_t PINS_REFUSED = '{BUS_RELEASED, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0};

	typedef struct packed {
		item_t   item;
		logic    until_idle;
		logic    typed;
		result_t pins;
	} stim_row_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              req_valid = 1'b0;
	logic              req_stall;
	item_t             req = '0;
	logic              res_valid;
	logic              res_stall = 1'b0;
	result_t           res;
	logic              psel = 1'b0;
	logic              penable = 1'b0;
	logic              pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [DATA_W-1:0] pwdata = '0;
	logic [DATA_W-1:0] prdata;
	logic              pready;

	// sequencer state as predicted
	cfg_t                  timing = '{16'd100, 16'd1, 16'd5, 16'd1, 16'd2, 16'd5};
	phase_t                seq_phase = PH_IDLE;
	logic [TIMER_BITS-1:0] seq_wait = '0;
	logic [7:0]            seq_byte = '0;
	logic                  seq_select = 1'b0;
	logic                  seq_low_next = 1'b0;
	logic [3:0]            seq_step = '0;
	logic                  seq_in_init = 1'b0;
	logic                  seq_long = 1'b0;
	logic                  seq_done = 1'b0;

	result_t pins_due[$];
	int      failures = 0;
	int      stall_left = 0;
	logic    idle_on = 1'b1;

	stim_row_t dir_table [0:19] = '{
		'{TICK_ITEM, 1'b0, 1'b1, PINS_IDLE},
		'{'{OP_UNUSED, 8'hFF, 1'b1}, 1'b0, 1'b1, PINS_IDLE},
		'{'{OP_WRITE, 8'hFF, 1'b0}, 1'b0, 1'b1, PINS_BUSY},
		'{'{OP_WRITE, 8'h00, 1'b1}, 1'b0, 1'b1, PINS_REFUSED},
		'{'{OP_INIT, 8'hA5, 1'b0}, 1'b0, 1'b1, PINS_REFUSED},
		'{'{OP_UNUSED, 8'h00, 1'b0}, 1'b0, 1'b1, PINS_BUSY},
		'{TICK_ITEM, 1'b1, 1'b0, '0},
		'{'{OP_WRITE, 8'h00, 1'b1}, 1'b0, 1'b1,
			'{8'h0F, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0}},
		'{TICK_ITEM, 1'b1, 1'b0, '0},
		'{'{OP_WRITE, CMD_CLEAR, 1'b0}, 1'b0, 1'b0, '0},
		'{TICK_ITEM, 1'b1, 1'b0, '0},
		'{'{OP_WRITE, CMD_CLEAR, 1'b1}, 1'b0, 1'b0, '0},
		'{TICK_ITEM, 1'b1, 1'b0, '0},
		'{'{OP_WRITE, CMD_HOME, 1'b0}, 1'b0, 1'b0, '0},
		'{TICK_ITEM, 1'b1, 1'b0, '0},
		'{'{OP_WRITE, 8'h5A, 1'b1}, 1'b0, 1'b0, '0},
		'{TICK_ITEM, 1'b1, 1'b0, '0},
		'{'{OP_INIT, 8'h00, 1'b1}, 1'b0, 1'b0, '0},
		'{TICK_ITEM, 1'b1, 1'b0, '0},
		'{TICK_ITEM, 1'b0, 1'b1, PINS_IDLE}
	};

	char_lcd_4bit_write_sequencer_top i_dut (
		.clk,
		.arst_n,
		.req_valid,
		.req_stall,
		.req,
		.res_valid,
		.res_stall,
		.res,
		.psel,
		.penable,
		.pwrite,
		.paddr,
		.pwdata,
		.prdata,
		.pready
	);

	always #10 clk = ~clk;

	function automatic void enter_phase(input phase_t p, input int unsigned d);
		seq_phase = p;
		if (d > TIMER_MAX) begin
			seq_wait = TIMER_MAX[TIMER_BITS-1:0];
		end else begin
			seq_wait = TIMER_BITS'(d);
		end
	endfunction

	function automatic logic [7:0] init_byte(input logic [3:0] n);
		case (n)
			4'd0, 4'd1, 4'd2: init_byte = INIT_NIB_A;
			4'd3: init_byte = INIT_NIB_B;
			4'd4: init_byte = CMD_FUNCTION_SET;
			4'd5: init_byte = CMD_DISPLAY_OFF;
			4'd6: init_byte = CMD_CLEAR;
			4'd7: init_byte = CMD_ENTRY_MODE;
			default: init_byte = CMD_DISPLAY_ON;
		endcase
	endfunction

	function automatic void load_init_item();
		seq_low_next = 1'b0;
		seq_select = 1'b0;
		seq_byte = init_byte(seq_step);
		seq_long = seq_byte == CMD_CLEAR || seq_byte == CMD_HOME;
		enter_phase(PH_SETUP, 32'(timing.setup_ticks));
	endfunction

	function automatic void finish_seq();
		seq_phase = PH_IDLE;
		seq_wait = '0;
		seq_in_init = 1'b0;
		seq_step = '0;
		seq_low_next = 1'b0;
		seq_long = 1'b0;
		seq_done = 1'b1;
	endfunction

	function automatic void advance_phase();
		int unsigned gap;
		case (seq_phase)
			PH_POWER: load_init_item();
			PH_SETUP: begin
				enter_phase(PH_ENABLE,
					timing.enable_ticks == '0 ? 32'd1 : 32'(timing.enable_ticks));
			end
			PH_ENABLE: enter_phase(PH_HOLD, 32'(timing.hold_ticks));
			PH_HOLD: begin
				if (seq_in_init && seq_step < INIT_NIBBLES) begin
					if (seq_step < 4'd2) begin
						gap = 32'(timing.long_cmd_extra_ticks);
					end else if (seq_step == 4'd2) begin
						gap = 32'(timing.post_write_ticks);
					end else begin
						gap = 0;
					end
					enter_phase(PH_GAP, gap);
				end else if (!seq_low_next) begin
					seq_low_next = 1'b1;
					enter_phase(PH_SETUP, 32'(timing.setup_ticks));
				end else begin
					seq_low_next = 1'b0;
					enter_phase(PH_GAP, 32'(timing.post_write_ticks) +
						(seq_long ? 32'(timing.long_cmd_extra_ticks) : 32'd0));
				end
			end
			PH_GAP: begin
				if (seq_in_init) begin
					seq_step = seq_step + 4'd1;
					if (seq_step < INIT_TOTAL) begin
						load_init_item();
					end else begin
						finish_seq();
					end
				end else begin
					finish_seq();
				end
			end
			default: finish_seq();
		endcase
	endfunction

	// zero-length phases pass within the same tick
	function automatic void settle_phases();
		int guard;
		guard = 0;
		while (seq_phase != PH_IDLE && seq_wait == '0 && guard < 64) begin
			advance_phase();
			guard++;
		end
	endfunction

	function automatic result_t predict_pins(input item_t it);
		result_t r;
		logic [3:0] nib;
		logic busy;
		r = '0;
		busy = seq_phase != PH_IDLE;
		seq_done = 1'b0;
		case (it.op)
			OP_TICK: begin
				if (busy) begin
					if (seq_wait != '0) begin
						seq_wait = seq_wait - 1'b1;
					end
					settle_phases();
				end
			end
			OP_WRITE, OP_INIT: begin
				if (busy) begin
					r.rejected = 1'b1;
				end else if (it.op == OP_WRITE) begin
					seq_byte = it.byte_value;
					seq_select = it.is_data;
					seq_long = !it.is_data &&
						(it.byte_value == CMD_CLEAR || it.byte_value == CMD_HOME);
					seq_low_next = 1'b0;
					seq_in_init = 1'b0;
					enter_phase(PH_SETUP, 32'(timing.setup_ticks));
					settle_phases();
				end else begin
					seq_in_init = 1'b1;
					seq_step = '0;
					seq_select = 1'b0;
					seq_low_next = 1'b0;
					seq_long = 1'b0;
					enter_phase(PH_POWER, 32'(timing.power_up_ticks));
					settle_phases();
				end
			end
			default: ;
		endcase

		// init nibbles sit in the upper half of their byte
		if (seq_phase == PH_GAP) begin
			nib = (seq_in_init && seq_step < INIT_NIBBLES) ? seq_byte[7:4] : seq_byte[3:0];
		end else begin
			nib = seq_low_next ? seq_byte[3:0] : seq_byte[7:4];
		end
		if (seq_phase == PH_IDLE || seq_phase == PH_POWER) begin
			r.bus_out = BUS_RELEASED;
		end else begin
			r.bus_out = {nib, NIB_ONES};
		end
		r.select_out = seq_in_init ? 1'b0 : seq_select;
		r.rw_out = 1'b0;
		r.enable_out = seq_phase == PH_ENABLE;
		r.busy_res = seq_phase != PH_IDLE;
		r.done_res = seq_done;
		return r;
	endfunction

	task automatic issue_request(input item_t it, input logic typed, input result_t pins);
		int gap;
		result_t r;
		gap = idle_on ? $urandom_range(0, 8) : 0;
		if (gap != 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req <= it;
		req_valid <= 1'b1;
		do @(posedge clk); while (req_stall);
		r = predict_pins(it);
		pins_due.push_back(typed ? pins : r);
	endtask

	task automatic drain_ticks();
		while (seq_phase != PH_IDLE) begin
			issue_request(TICK_ITEM, 1'b0, '0);
		end
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [CFG_W-1:0] v);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= {16'($urandom), v};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		case (idx)
			REG_POWER_UP: timing.power_up_ticks = v;
			REG_SETUP: timing.setup_ticks = v;
			REG_ENABLE: timing.enable_ticks = v;
			REG_HOLD: timing.hold_ticks = v;
			REG_POST_WRITE: timing.post_write_ticks = v;
			REG_LONG_EXTRA: timing.long_cmd_extra_ticks = v;
			default: ;
		endcase
	endtask

	task automatic retime(input cfg_t knobs);
		drain_ticks();
		req_valid <= 1'b0;
		while (pins_due.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		write_reg(REG_POWER_UP, knobs.power_up_ticks);
		write_reg(REG_SETUP, knobs.setup_ticks);
		write_reg(REG_ENABLE, knobs.enable_ticks);
		write_reg(REG_HOLD, knobs.hold_ticks);
		write_reg(REG_POST_WRITE, knobs.post_write_ticks);
		write_reg(REG_LONG_EXTRA, knobs.long_cmd_extra_ticks);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// mostly complete writes and inits, with requests thrown in while busy
	task automatic run_random(input int n);
		item_t it;
		int pick;
		int counted;
		counted = 0;
		while (counted < n) begin
			pick = $urandom_range(0, 99);
			it.byte_value = 8'($urandom);
			it.is_data = 1'($urandom);
			if (seq_phase == PH_IDLE) begin
				it.op = pick < 45 ? OP_WRITE : pick < 55 ? OP_INIT :
					pick < 60 ? OP_UNUSED : OP_TICK;
			end else begin
				it.op = pick < 85 ? OP_TICK : pick < 91 ? OP_WRITE :
					pick < 96 ? OP_INIT : OP_UNUSED;
			end
			if (it.op == OP_WRITE && $urandom_range(0, 4) == 0) begin
				it.byte_value = $urandom_range(0, 1) ? CMD_CLEAR : CMD_HOME;
			end
			if (it.op == OP_WRITE || it.op == OP_INIT ||
					(it.op == OP_TICK && seq_phase != PH_IDLE)) begin
				counted++;
			end
			issue_request(it, 1'b0, '0);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		int hold;
		if (!arst_n) begin
			res_stall <= 1'b0;
			stall_left <= 0;
		end else if (res_valid && !res_stall) begin
			hold = idle_on ? $urandom_range(0, 8) : 0;
			stall_left <= hold;
			res_stall <= hold != 0;
		end else if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			res_stall <= stall_left > 1;
		end
	end

	always @(posedge clk) begin
		result_t want;
		if (res_valid && !res_stall) begin
			if (pins_due.size() == 0) begin
				failures++;
				if (failures <= MAX_REPORTS) begin
					$display("result %h arrived with no request pending", res);
				end
			end else begin
				want = pins_due.pop_front();
				if (res !== want) begin
					failures++;
					if (failures <= MAX_REPORTS) begin
						$display("pins mismatch (expected/actual): bus %h/%h rs %b/%b rw %b/%b",
							want.bus_out, res.bus_out, want.select_out, res.select_out,
							want.rw_out, res.rw_out);
						$display("  en %b/%b busy %b/%b rej %b/%b done %b/%b",
							want.enable_out, res.enable_out, want.busy_res, res.busy_res,
							want.rejected, res.rejected, want.done_res, res.done_res);
					end
				end
			end
		end
	end

	initial begin
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((req_valid && !req_stall) || (res_valid && !res_stall)) begin
				quiet = 0;
			end else begin
				quiet++;
			end
		end
		$display("Test completed with failures");
		$finish;
	end

	initial begin
		cfg_t knobs;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		foreach (dir_table[i]) begin
			if (dir_table[i].until_idle) begin
				drain_ticks();
			end else begin
				issue_request(dir_table[i].item, dir_table[i].typed, dir_table[i].pins);
			end
		end
		run_random(RANDOM_REQUESTS);

		retime('{16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0});
		run_random(RANDOM_REQUESTS);

		for (int k = 0; k < 3; k++) begin
			knobs.power_up_ticks = 16'($urandom_range(0, 12));
			knobs.setup_ticks = 16'($urandom_range(0, 4));
			knobs.enable_ticks = 16'($urandom_range(0, 4));
			knobs.hold_ticks = 16'($urandom_range(0, 4));
			knobs.post_write_ticks = 16'($urandom_range(0, 6));
			knobs.long_cmd_extra_ticks = 16'($urandom_range(0, 6));
			idle_on = k != 1;
			retime(knobs);
			run_random(RANDOM_REQUESTS);
		end

		// clear whose post-write gap plus extra wait runs past the timer range
		idle_on = 1'b0;
		retime('{16'd0, 16'd0, 16'd1, 16'd0, 16'hFFFF, 16'h0001});
		issue_request('{OP_WRITE, CMD_CLEAR, 1'b0}, 1'b0, '0);
		repeat (SAT_TICKS) issue_request(TICK_ITEM, 1'b0, '0);

		req_valid <= 1'b0;
		while (pins_due.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (failures == 0 && pins_due.size() == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule

`default_nettype wire

// ----- files.f -----
hdl/lcdws_pkg.sv
hdl/lcdws_cfg.sv
hdl/lcdws_front.sv
hdl/lcdws_seq.sv
hdl/char_lcd_4bit_write_sequencer_top.sv
test/tb_char_lcd_4bit_write_sequencer_top.sv
